// File: rtl/pfgc_pkg.sv
// Package for the PEC-15 frame generator and checker.
// Holds the CRC-15 table step, the result request type and the tuser bit positions.
// Used by pfgc_emit and pec15_frame_gen_check.
package pfgc_pkg;

    localparam logic [15:0] PEC_INIT = 16'd16;
    localparam logic [15:0] PEC_POLY = 16'h4599;

    // tuser bit positions on the result channel
    localparam int USER_IS_PEC = 0;
    localparam int USER_CHECK  = 1;
    localparam int USER_OK     = 2;
    localparam int USER_W      = 3;

    // Result request handed from the frame logic to the output stage
    typedef struct packed {
        logic        valid;    // the accepted item gives a result
        logic        append;   // transmit last byte: two code bytes follow the echo
        logic        check;    // receive check result
        logic        ok;       // check passed
        logic [7:0]  data;     // echoed byte (zero for a check)
        logic [15:0] code;     // code to append
    } t_req;

    // One entry of the CRC-15 table: eight shift-and-reduce steps
    function automatic logic [15:0] pec_table(input logic [7:0] idx);
        logic [15:0] r;
        r = {1'b0, idx, 7'b0};
        for (int k = 0; k < 8; k++) begin
            if (r[14]) begin
                r = {r[14:0], 1'b0} ^ PEC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // One byte through the remainder
    function automatic logic [15:0] pec_step(input logic [15:0] rem, input logic [7:0] b);
        logic [7:0] idx;
        idx = rem[14:7] ^ b;
        return {rem[7:0], 8'h00} ^ pec_table(idx);
    endfunction

endpackage

// File: rtl/pec15_frame_gen_check.sv
// PEC-15 frame generator and checker, top level.
// Holds the transmit and receive remainders and the receive hold queue.
// Depends on pfgc_pkg and pfgc_emit.
//
// Usage:
//   Input channel (i_s_*): one byte per item. tdata = data_byte, tuser[0] = action
//   (0 transmit, 1 receive check), tlast = last byte of the frame.
//   Result channel (o_m_*): tdata = out_byte, tuser = {pec_ok, check_done, is_pec},
//   tlast = end_of_frame.
//   Transmit bytes are echoed in the cycle after acceptance. The last transmit byte is
//   followed by the 15-bit code doubled, high byte then low byte; the low byte
//   carries tlast. Receive bytes give nothing until the last one, which gives one
//   check result with tlast set; frames under three bytes fail the check.
//   One item is taken every cycle while the receiver keeps up; a last transmit byte
//   holds the result register for its echo and both code bytes, and no new item is
//   taken until the low code byte is being taken. The CRC table step and the
//   result register set this rate.
//   Reset sets both remainders to 16 and empties the receive queue and the result
//   register. When the receiver stalls, the result register holds and o_s_tready
//   falls until the shown result is taken.
module pec15_frame_gen_check
    import pfgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // data_byte
    input  logic              i_s_tuser,   // action
    input  logic              i_s_tlast,   // last_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // out_byte
    output logic [USER_W-1:0] o_m_tuser,   // is_pec, check_done, pec_ok (from bit 0)
    output logic              o_m_tlast    // end_of_frame
);

    logic [15:0] r_tx_rem;
    logic [15:0] r_rx_rem;
    logic [1:0]  r_rx_cnt;
    logic [7:0]  r_hold0;
    logic [7:0]  r_hold1;

    logic        take;
    logic [15:0] n_tx_rem;
    logic [15:0] rx_rem_step;
    logic [15:0] rx_code;
    logic        rx_ok;
    t_req        req;

    assign take = i_s_tvalid && o_s_tready;

    // remainder steps and the check compare
    always_comb begin
        n_tx_rem    = pec_step(r_tx_rem, i_s_tdata);
        rx_rem_step = pec_step(r_rx_rem, r_hold0);
        rx_code     = {rx_rem_step[14:0], 1'b0};
        rx_ok       = (r_rx_cnt == 2'd2) && (rx_code == {r_hold1, i_s_tdata});
    end

    // result request for the output stage
    always_comb begin
        req        = '0;
        req.code   = {n_tx_rem[14:0], 1'b0};
        if (!i_s_tuser) begin
            req.valid  = 1'b1;
            req.append = i_s_tlast;
            req.data   = i_s_tdata;
        end else if (i_s_tlast) begin
            req.valid  = 1'b1;
            req.check  = 1'b1;
            req.ok     = rx_ok;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_rem <= PEC_INIT;
            r_rx_rem <= PEC_INIT;
            r_rx_cnt <= 2'd0;
        end else if (take) begin
            if (!i_s_tuser) begin
                r_tx_rem <= i_s_tlast ? PEC_INIT : n_tx_rem;
            end else if (i_s_tlast) begin
                r_rx_rem <= PEC_INIT;
                r_rx_cnt <= 2'd0;
            end else if (r_rx_cnt == 2'd2) begin
                r_rx_rem <= rx_rem_step;
                r_hold0  <= r_hold1;
                r_hold1  <= i_s_tdata;
            end else begin
                if (r_rx_cnt[0]) begin
                    r_hold1 <= i_s_tdata;
                end else begin
                    r_hold0 <= i_s_tdata;
                end
                r_rx_cnt <= r_rx_cnt + 2'd1;
            end
        end
    end

    pfgc_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_req      (req),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // receive queue never exceeds two bytes
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_cnt != 2'd3)
        else $error("receive hold count out of range");

    // a framed transmit byte restarts the transmit remainder
    a_tx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_s_tuser && i_s_tlast) |=> (r_tx_rem == PEC_INIT))
        else $error("transmit remainder not restarted");

    // a receive last byte empties the queue
    a_rx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_s_tuser && i_s_tlast) |=> (r_rx_cnt == 2'd0 && r_rx_rem == PEC_INIT))
        else $error("receive state not cleared");

endmodule

// File: rtl/pfgc_emit.sv
// Output stage: result register plus the sequencer for the two appended code bytes.
// Depends on pfgc_pkg (t_req, tuser bit positions).
module pfgc_emit
    import pfgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,     // an item is accepted this cycle
    input  t_req              i_req,
    output logic              o_ready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,  // out_byte
    output logic [USER_W-1:0] o_m_tuser,  // is_pec, check_done, pec_ok (from bit 0)
    output logic              o_m_tlast   // end_of_frame
);

    logic              r_valid;
    logic [7:0]        r_data;
    logic [USER_W-1:0] r_user;
    logic              r_last;
    logic [1:0]        r_pend;   // code bytes still to show
    logic [7:0]        r_data_hi;
    logic [7:0]        r_code_lo;

    logic              pop;
    logic [USER_W-1:0] user_pec;   // tuser of an appended code byte
    logic [USER_W-1:0] user_take;  // tuser of a newly accepted item
    assign pop     = r_valid && i_m_tready;
    assign o_ready = (r_pend == 2'd0) && (!r_valid || i_m_tready);

    // tuser patterns
    always_comb begin
        user_pec               = '0;
        user_pec[USER_IS_PEC]  = 1'b1;
        user_take              = '0;
        user_take[USER_CHECK]  = i_req.check;
        user_take[USER_OK]     = i_req.ok;
    end

    // result register and code byte sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 2'd0;
        end else if (pop && r_pend == 2'd2) begin
            r_data               <= r_data_hi;
            r_user               <= user_pec;
            r_last               <= 1'b0;
            r_pend               <= 2'd1;
        end else if (pop && r_pend == 2'd1) begin
            r_data               <= r_code_lo;
            r_user               <= user_pec;
            r_last               <= 1'b1;
            r_pend               <= 2'd0;
        end else if (i_take) begin
            r_valid             <= i_req.valid;
            r_data              <= i_req.data;
            r_user              <= user_take;
            r_last              <= i_req.check;
            r_pend              <= i_req.append ? 2'd2 : 2'd0;
            r_data_hi           <= i_req.code[15:8];
            r_code_lo           <= i_req.code[7:0];
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;
    assign o_m_tlast  = r_last;

    // code bytes pending means a result is shown
    a_pend_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd0) |-> r_valid)
        else $error("code bytes pending without a shown result");

    // no item is taken while code bytes are outstanding
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> (r_pend == 2'd0))
        else $error("item accepted while code bytes pending");

    // taking the echo of a framed transmit byte brings up the high code byte
    a_hi_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_pend == 2'd2) |=> (r_valid && r_user[USER_IS_PEC] && !r_last))
        else $error("high code byte not shown after echo");

    // a check result always closes the frame
    a_check_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_user[USER_CHECK]) |-> (r_last && !r_user[USER_IS_PEC]))
        else $error("check result without end of frame");

endmodule

// File: sim/tb_pec15_frame_gen_check.sv
// Testbench for pec15_frame_gen_check: random transmit and receive frames with bursty input
// and a stalling receiver, every result checked against a PEC-15 predictor in this file.
// Depends on pfgc_pkg (tuser bit positions) and the pec15_frame_gen_check RTL.
`timescale 1ns / 1ps

module tb_pec15_frame_gen_check;

    localparam logic [15:0] PEC_SEED       = 16'd16;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_OFF_LEN   = 300;
    localparam int          RANDOM_ITEMS   = 260;
    localparam int          DRAIN_CYCLES   = 8;

    // Direction of an input item, carried on tuser
    typedef enum logic {
        DIR_TX = 1'b0,
        DIR_RX = 1'b1
    } t_dir;

    // Kinds of receive frame the stimulus builds
    typedef enum int {
        RX_GOOD,
        RX_BAD,
        RX_SHORT
    } t_rx_kind;

    // Receiver back-pressure patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } t_stall_mode;

    typedef struct {
        t_dir       dir;
        logic [7:0] value;
        logic       last;
    } t_byte_item;

    typedef struct {
        logic [7:0] out_byte;
        logic       is_pec;
        logic       end_of_frame;
        logic       check_done;
        logic       pec_ok;
    } t_pec_result;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [7:0]                   i_s_tdata  = 8'h00;   // data_byte
    logic                         i_s_tuser  = 1'b0;    // action
    logic                         i_s_tlast  = 1'b0;    // last_byte
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [7:0]                   o_m_tdata;            // out_byte
    logic [pfgc_pkg::USER_W-1:0]  o_m_tuser;            // is_pec, check_done, pec_ok
    logic                         o_m_tlast;            // end_of_frame

    // Stimulus and expectation stores
    t_byte_item  byte_q[$];
    t_byte_item  frame_q[$];
    t_byte_item  side_q[$];
    t_pec_result want_results[$];

    // Predictor state
    logic [15:0] tx_rem   = PEC_SEED;
    logic [15:0] rx_rem   = PEC_SEED;
    int          rx_fill  = 0;
    logic [7:0]  rx_held [2] = '{8'h00, 8'h00};

    int          mismatches   = 0;
    int          items_taken  = 0;
    int          quiet_cycles = 0;
    bit          byte_taken   = 1'b0;

    // Sender and receiver pacing
    t_byte_item  drv_item;
    int          burst_left = 0;
    int          gap_left   = 0;
    t_stall_mode stall_mode = RDY_ALWAYS;
    int          mode_left  = 0;
    int          stall_tick = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;

    t_pec_result want;

    pec15_frame_gen_check i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // One byte through the CRC-15 remainder, table entry worked out on the fly
    function automatic logic [15:0] pec15_step(input logic [15:0] rem, input logic [7:0] b);
        logic [15:0] entry;
        entry = {1'b0, rem[14:7] ^ b, 7'b0};
        for (int k = 0; k < 8; k++) begin
            entry = entry[14] ? ({entry[14:0], 1'b0} ^ 16'h4599) : {entry[14:0], 1'b0};
        end
        return {rem[7:0], 8'h00} ^ entry;
    endfunction

    function automatic t_pec_result pec_result(input logic [7:0] ob, input logic pec,
                                               input logic eof, input logic chk,
                                               input logic ok);
        t_pec_result r;
        r.out_byte     = ob;
        r.is_pec       = pec;
        r.end_of_frame = eof;
        r.check_done   = chk;
        r.pec_ok       = ok;
        return r;
    endfunction

    // Expected results of one accepted input item
    task automatic predict_pec_results(input t_dir dir, input logic [7:0] value,
                                       input logic last);
        logic [15:0] rem;
        logic [15:0] code;
        logic        good;
        if (dir == DIR_TX) begin
            tx_rem = pec15_step(tx_rem, value);
            want_results.push_back(pec_result(value, 1'b0, 1'b0, 1'b0, 1'b0));
            if (last) begin
                code = {tx_rem[14:0], 1'b0};
                want_results.push_back(pec_result(code[15:8], 1'b1, 1'b0, 1'b0, 1'b0));
                want_results.push_back(pec_result(code[7:0], 1'b1, 1'b1, 1'b0, 1'b0));
                tx_rem = PEC_SEED;
            end
        end else if (!last) begin
            // two newest bytes stay held back as the candidate code
            if (rx_fill == 2) begin
                rx_rem     = pec15_step(rx_rem, rx_held[0]);
                rx_held[0] = rx_held[1];
                rx_held[1] = value;
            end else begin
                rx_held[rx_fill] = value;
                rx_fill++;
            end
        end else begin
            good = 1'b0;
            if (rx_fill == 2) begin
                rem  = pec15_step(rx_rem, rx_held[0]);
                code = {rem[14:0], 1'b0};
                good = (code == {rx_held[1], value});
            end
            want_results.push_back(pec_result(8'h00, 1'b0, 1'b1, 1'b1, good));
            rx_rem     = PEC_SEED;
            rx_fill    = 0;
            rx_held[0] = 8'h00;
            rx_held[1] = 8'h00;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Frame building into frame_q
    task automatic add_byte(input t_dir dir, input logic [7:0] value, input logic last);
        t_byte_item it;
        it.dir   = dir;
        it.value = value;
        it.last  = last;
        frame_q.push_back(it);
    endtask

    task automatic build_tx_frame(input int n, input int fixed);
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            b = (fixed < 0) ? 8'($urandom_range(0, 255)) : fixed[7:0];
            add_byte(DIR_TX, b, k == n - 1);
        end
    endtask

    // n is the payload length, or the whole length for a short frame
    task automatic build_rx_frame(input int n, input t_rx_kind kind, input int fixed);
        logic [15:0] rem;
        logic [15:0] code;
        logic [7:0]  b;
        logic [7:0]  flip;
        int          flip_pos;
        rem      = PEC_SEED;
        flip     = 8'(1 << $urandom_range(0, 7));
        flip_pos = (kind == RX_BAD) ? $urandom_range(0, n + 1) : -1;
        if (kind == RX_SHORT) begin
            for (int k = 0; k < n; k++) begin
                b = (fixed < 0) ? 8'($urandom_range(0, 255)) : fixed[7:0];
                add_byte(DIR_RX, b, k == n - 1);
            end
        end else begin
            for (int k = 0; k < n; k++) begin
                b   = (fixed < 0) ? 8'($urandom_range(0, 255)) : fixed[7:0];
                rem = pec15_step(rem, b);
                add_byte(DIR_RX, (k == flip_pos) ? (b ^ flip) : b, 1'b0);
            end
            code = {rem[14:0], 1'b0};
            add_byte(DIR_RX, (flip_pos == n) ? (code[15:8] ^ flip) : code[15:8], 1'b0);
            add_byte(DIR_RX, (flip_pos == n + 1) ? (code[7:0] ^ flip) : code[7:0], 1'b1);
        end
    endtask

    task automatic commit_frame();
        while (frame_q.size() > 0) begin
            byte_q.push_back(frame_q.pop_front());
        end
    endtask

    // Receive frame and transmit frame mixed byte by byte
    task automatic interleave_with_tx(input int rx_n, input t_rx_kind kind, input int tx_n);
        build_rx_frame(rx_n, kind, -1);
        while (frame_q.size() > 0) begin
            side_q.push_back(frame_q.pop_front());
        end
        build_tx_frame(tx_n, -1);
        while (frame_q.size() > 0 || side_q.size() > 0) begin
            if (side_q.size() == 0 || (frame_q.size() > 0 && $urandom_range(0, 1) == 1)) begin
                byte_q.push_back(frame_q.pop_front());
            end else begin
                byte_q.push_back(side_q.pop_front());
            end
        end
    endtask

    // Input accept: feed the predictor
    always @(posedge i_clk) begin
        byte_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (byte_taken) begin
            items_taken++;
            predict_pec_results(t_dir'(i_s_tuser), i_s_tdata, i_s_tlast);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (want_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, byte %02h", o_m_tdata));
            end else begin
                want = want_results.pop_front();
                if (o_m_tdata !== want.out_byte) begin
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              o_m_tdata, want.out_byte));
                end
                if (o_m_tuser[pfgc_pkg::USER_IS_PEC] !== want.is_pec) begin
                    report_mismatch($sformatf("is_pec %b, want %b",
                                              o_m_tuser[pfgc_pkg::USER_IS_PEC], want.is_pec));
                end
                if (o_m_tlast !== want.end_of_frame) begin
                    report_mismatch($sformatf("end_of_frame %b, want %b",
                                              o_m_tlast, want.end_of_frame));
                end
                if (o_m_tuser[pfgc_pkg::USER_CHECK] !== want.check_done) begin
                    report_mismatch($sformatf("check_done %b, want %b",
                                              o_m_tuser[pfgc_pkg::USER_CHECK], want.check_done));
                end
                if (o_m_tuser[pfgc_pkg::USER_OK] !== want.pec_ok) begin
                    report_mismatch($sformatf("pec_ok %b, want %b",
                                              o_m_tuser[pfgc_pkg::USER_OK], want.pec_ok));
                end
            end
        end
    end

    // Driver: bursts of items separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || byte_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                drv_item = byte_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= drv_item.value;
                i_s_tuser  <= drv_item.dir;
                i_s_tlast  <= drv_item.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off mid-run
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!hold_done && items_taken >= 120) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_LEN;
            i_m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 90);
            end
            mode_left--;
            stall_tick++;
            case (stall_mode)
                RDY_ALWAYS: begin
                    i_m_tready <= 1'b1;
                end
                RDY_COIN: begin
                    i_m_tready <= 1'($urandom_range(0, 1));
                end
                RDY_SPARSE: begin
                    i_m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_m_tready <= (stall_tick % 5 != 0);
                end
            endcase
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_pec15_frame_gen_check NOT OK");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int       pick;
        int       base;
        t_rx_kind kind;

        // directed: byte extremes, short and minimal receive frames, interleaving
        build_tx_frame(1, 0);
        commit_frame();
        build_tx_frame(1, 255);
        commit_frame();
        build_rx_frame(1, RX_SHORT, 255);
        commit_frame();
        build_rx_frame(2, RX_SHORT, 0);
        commit_frame();
        build_rx_frame(1, RX_GOOD, 0);
        commit_frame();
        build_rx_frame(1, RX_BAD, 255);
        commit_frame();
        build_tx_frame(3, -1);
        commit_frame();
        interleave_with_tx(2, RX_GOOD, 2);

        // random: mostly well-formed receive frames, some broken ones and transmit frames
        base = byte_q.size();
        while (byte_q.size() - base < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                build_rx_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                           : $urandom_range(1, 6),
                               RX_GOOD, -1);
                commit_frame();
            end else if (pick < 62) begin
                build_rx_frame($urandom_range(1, 6), RX_BAD, -1);
                commit_frame();
            end else if (pick < 70) begin
                build_rx_frame($urandom_range(1, 2), RX_SHORT, -1);
                commit_frame();
            end else if (pick < 88) begin
                build_tx_frame($urandom_range(1, 8), -1);
                commit_frame();
            end else begin
                kind = ($urandom_range(0, 3) == 0) ? RX_BAD : RX_GOOD;
                interleave_with_tx($urandom_range(1, 5), kind, $urandom_range(1, 5));
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || i_s_tvalid) begin
            @(negedge i_clk);
        end
        while (want_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && want_results.size() == 0) begin
            $display("tb_pec15_frame_gen_check OK");
        end else begin
            $display("tb_pec15_frame_gen_check NOT OK");
        end
        $finish;
    end

endmodule
